FILE: rtl/gbr_pkg.sv
// Shared constants and types for the Gaussian blur with border renormalization.
// No dependencies; imported by gbr_queue, gbr_front, gbr_back and the top level.
package gbr_pkg;

  // Default values of the top level parameters
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int RADIUS_DEF    = 3;
  localparam int COEF_BITS_DEF = 16;

  // Fixed widths
  localparam int ROW_W      = 13;  // row counters, can hold the frame height itself
  localparam int JOB_COL_W  = 12;  // column field of a job, covers the largest line
  localparam int SLOT_W     = 3;   // ring row index, at most eight rows
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE   = 3'd5;

  // Register reset values
  localparam logic [FW_W-1:0]       FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]       FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CFG_DATA_W-1:0] COEF_CENTER_RST  = 16'd26152;
  localparam logic [CFG_DATA_W-1:0] COEF_ONE_RST     = 16'd15862;
  localparam logic [CFG_DATA_W-1:0] COEF_TWO_RST     = 16'd3539;
  localparam logic [CFG_DATA_W-1:0] COEF_THREE_RST   = 16'd290;

  // Item kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // One output pixel to compute
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [JOB_COL_W-1:0] col;
    logic [SLOT_W-1:0]    slot;
    logic                 last;
  } job_t;

endpackage

FILE: rtl/gbr_in_if.sv
// Input channel of the blur block: pixel or drain items.
// No dependencies.
interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

FILE: rtl/gbr_out_if.sv
// Output channel of the blur block: smoothed pixels.
// No dependencies.
interface gbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

FILE: rtl/gbr_ram.sv
// Generic single write, single registered read memory.
// No dependencies.
module gbr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/gbr_queue.sv
// Two entry job queue between the front and back parts.
// Depends on gbr_pkg for job_t.
module gbr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbr_pkg::job_t push_job,
  input  logic          pop,
  output logic          valid,
  output logic          empty,
  output gbr_pkg::job_t head
);
  import gbr_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign valid = (count != 2'd0);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/gbr_front.sv
// Front part: accepts items, stores pixels in the line ring, tracks input and
// output positions and issues one job per output pixel. Depends on gbr_pkg.
module gbr_front #(
  parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = gbr_pkg::RADIUS_DEF,
  parameter int EW_W      = $clog2(MAX_WIDTH + 1),
  parameter int ADDR_W    = $clog2((2 * RADIUS + 2) * MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic                      hold,
  input  logic [EW_W-1:0]           eff_w,
  input  logic [gbr_pkg::ROW_W-1:0] eff_h,
  gbr_in_if.sink                    src,
  output logic                      ram_we,
  output logic [ADDR_W-1:0]         ram_waddr,
  output logic [7:0]                ram_wdata,
  output logic                      push,
  output gbr_pkg::job_t             push_job
);
  import gbr_pkg::*;

  localparam int RING  = 2 * RADIUS + 2;
  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [COL_W-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [ROW_W-1:0]  in_row, in_row_next, out_row, out_row_next;
  logic [SLOT_W-1:0] in_slot, in_slot_next, out_slot, out_slot_next;

  logic            accept, do_pix, out_ready, last;
  logic [ROW_W:0]  row_reach, row_max, row_need;
  logic [EW_W:0]   col_reach, col_max, col_need, col_inc;

  assign src.ready = ~hold;
  assign accept    = src.valid & ~hold;
  assign do_pix    = (src.action == ACT_PIXEL) && (in_row < eff_h);

  assign ram_we    = accept & do_pix;
  assign ram_waddr = ADDR_W'(in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign ram_wdata = src.pixel_in;

  assign last = (out_row == eff_h - ROW_W'(1)) && ({1'b0, out_col} == eff_w - EW_W'(1));

  always_comb begin
    in_col_next   = in_col;
    in_row_next   = in_row;
    in_slot_next  = in_slot;
    out_col_next  = out_col;
    out_row_next  = out_row;
    out_slot_next = out_slot;
    col_inc       = (EW_W + 1)'(in_col) + (EW_W + 1)'(1);

    if (do_pix) begin
      if (col_inc >= {1'b0, eff_w}) begin
        in_col_next  = '0;
        in_row_next  = in_row + ROW_W'(1);
        in_slot_next = (in_slot == SLOT_W'(RING - 1)) ? '0 : in_slot + SLOT_W'(1);
      end else begin
        in_col_next = COL_W'(col_inc);
      end
    end

    // lowest row and column that must have arrived before this output
    row_reach = {1'b0, out_row} + (ROW_W + 1)'(RADIUS);
    row_max   = {1'b0, eff_h} - (ROW_W + 1)'(1);
    row_need  = (row_reach > row_max) ? row_max : row_reach;
    col_reach = (EW_W + 1)'(out_col) + (EW_W + 1)'(RADIUS);
    col_max   = {1'b0, eff_w} - (EW_W + 1)'(1);
    col_need  = (col_reach > col_max) ? col_max : col_reach;
    out_ready = ({1'b0, in_row_next} > row_need) ||
                (({1'b0, in_row_next} == row_need) && ((EW_W + 1)'(in_col_next) > col_need));

    if (out_ready) begin
      if ((EW_W + 1)'(out_col) + (EW_W + 1)'(1) >= {1'b0, eff_w}) begin
        out_col_next = '0;
        if (last) begin
          // frame done: both sides start over
          out_row_next  = '0;
          out_slot_next = '0;
          in_row_next   = '0;
          in_col_next   = '0;
          in_slot_next  = '0;
        end else begin
          out_row_next  = out_row + ROW_W'(1);
          out_slot_next = (out_slot == SLOT_W'(RING - 1)) ? '0 : out_slot + SLOT_W'(1);
        end
      end else begin
        out_col_next = out_col + COL_W'(1);
      end
    end
  end

  assign push          = accept & out_ready;
  assign push_job.row  = out_row;
  assign push_job.col  = JOB_COL_W'(out_col);
  assign push_job.slot = out_slot;
  assign push_job.last = last;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else if (accept) begin
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      in_slot  <= in_slot_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      out_slot <= out_slot_next;
    end
  end

endmodule

FILE: rtl/gbr_back.sv
// Back part: walks the window taps of one job through the line ring, accumulates
// weighted sums, divides and drives the output register. Depends on gbr_pkg.
module gbr_back #(
  parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = gbr_pkg::RADIUS_DEF,
  parameter int COEF_BITS = gbr_pkg::COEF_BITS_DEF,
  parameter int EW_W      = $clog2(MAX_WIDTH + 1),
  parameter int ADDR_W    = $clog2((2 * RADIUS + 2) * MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [EW_W-1:0]           eff_w,
  input  logic [gbr_pkg::ROW_W-1:0] eff_h,
  input  logic [COEF_BITS-1:0]      coef [4],
  input  logic                      q_valid,
  input  gbr_pkg::job_t             q_head,
  output logic                      pop,
  output logic                      busy_last,
  output logic [ADDR_W-1:0]         ram_raddr,
  input  logic [7:0]                ram_rdata,
  gbr_out_if.source                 res
);
  import gbr_pkg::*;

  localparam int RING   = 2 * RADIUS + 2;
  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int TAP_W  = $clog2(SPAN + 1);
  localparam int WT_W   = 2 * COEF_BITS;
  localparam int PROD_W = WT_W + 8;
  localparam int NUM_W  = PROD_W + 6;
  localparam int DEN_W  = WT_W + 6;
  localparam int CS_W   = JOB_COL_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_TAPS, S_DRAIN, S_DIV, S_DONE} state_t;

  state_t            state;
  job_t              job;
  logic [TAP_W-1:0]  tdx, tdy;
  logic [SLOT_W-1:0] tslot;
  logic              drain_cnt;
  logic [2:0]        bit_i;
  logic [7:0]        quot;

  logic              s1_v, s2_v;
  logic [WT_W-1:0]   s1_wt, s2_wt;
  logic [PROD_W-1:0] s2_prod;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;

  logic              out_v;
  logic [7:0]        out_pix;
  logic              out_last;

  logic [ROW_W:0]    r_sum;
  logic [CS_W-1:0]   c_sum;
  logic              tap_in;
  logic [1:0]        dist_x, dist_y;
  logic [NUM_W-1:0]  trial;
  logic              out_free;

  assign r_sum  = {1'b0, job.row} + (ROW_W + 1)'(tdy);
  assign c_sum  = {1'b0, job.col} + CS_W'(tdx);
  assign tap_in = (r_sum >= (ROW_W + 1)'(RADIUS)) &&
                  (r_sum < {1'b0, eff_h} + (ROW_W + 1)'(RADIUS)) &&
                  (c_sum >= CS_W'(RADIUS)) &&
                  (c_sum < CS_W'(eff_w) + CS_W'(RADIUS));
  assign dist_x = (tdx >= TAP_W'(RADIUS)) ? 2'(tdx - TAP_W'(RADIUS)) : 2'(TAP_W'(RADIUS) - tdx);
  assign dist_y = (tdy >= TAP_W'(RADIUS)) ? 2'(tdy - TAP_W'(RADIUS)) : 2'(TAP_W'(RADIUS) - tdy);
  assign ram_raddr = ADDR_W'(tslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_sum - CS_W'(RADIUS));

  assign trial    = NUM_W'(den) << bit_i;
  assign out_free = ~out_v | res.ready;
  assign pop      = (state == S_IDLE) && q_valid;
  assign busy_last = (state != S_IDLE) && job.last;

  assign res.valid     = out_v;
  assign res.pixel_out = out_pix;
  assign res.frame_end = out_last;

  // tap pipeline: weight, then product, then accumulate
  always_ff @(posedge clk) begin
    s1_wt   <= coef[dist_x] * coef[dist_y];
    s2_wt   <= s1_wt;
    s2_prod <= s1_wt * ram_rdata;
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= (state == S_TAPS) && tap_in;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_v     <= 1'b0;
      tdx       <= '0;
      tdy       <= '0;
      drain_cnt <= 1'b0;
      bit_i     <= '0;
    end else begin
      if (out_v && res.ready) begin
        out_v <= 1'b0;
      end
      if (s2_v) begin
        num <= num + NUM_W'(s2_prod);
        den <= den + DEN_W'(s2_wt);
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            job   <= q_head;
            tdx   <= '0;
            tdy   <= '0;
            tslot <= (q_head.slot >= SLOT_W'(RADIUS)) ? q_head.slot - SLOT_W'(RADIUS)
                                                        : q_head.slot + SLOT_W'(RING - RADIUS);
            num   <= '0;
            den   <= '0;
            state <= S_TAPS;
          end
        end
        S_TAPS: begin
          if (tdx == TAP_W'(SPAN - 1)) begin
            tdx   <= '0;
            tdy   <= tdy + TAP_W'(1);
            tslot <= (tslot == SLOT_W'(RING - 1)) ? '0 : tslot + SLOT_W'(1);
            if (tdy == TAP_W'(SPAN - 1)) begin
              drain_cnt <= 1'b0;
              state     <= S_DRAIN;
            end
          end else begin
            tdx <= tdx + TAP_W'(1);
          end
        end
        S_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            bit_i <= 3'd7;
            quot  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (num >= trial) begin
            num         <= num - trial;
            quot[bit_i] <= 1'b1;
          end
          if (bit_i == 3'd0) begin
            state <= S_DONE;
          end else begin
            bit_i <= bit_i - 3'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_v    <= 1'b1;
            out_pix  <= (den == '0) ? 8'd0 : quot;
            out_last <= job.last;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/gaussian_blur_border_renorm_unit.sv
// Top level of the Gaussian blur with border renormalization.
// Depends on gbr_pkg, gbr_in_if, gbr_out_if, gbr_ram, gbr_front, gbr_queue, gbr_back.
//
// Usage:
//   src carries items in raster order: action 0 with a pixel, or action 1 as a
//   drain tick that flushes the last rows of a frame. res carries one smoothed
//   pixel per output position, raster order, frame_end on the frame's last one.
//   Each output is sum(p*w)/sum(w) over the in-frame taps of a square window,
//   w = coef[|dx|]*coef[|dy|], truncated.
//   Config: cfg_we/cfg_index/cfg_data write one register per cycle; the user must
//   write only while the block is idle, which the block does not enforce. A width or
//   height write restarts the frame.
// Flow:
//   The back part walks (2*RADIUS+1)^2 taps one per cycle through the single
//   read port of the line ring, then drains the tap pipeline, runs the restoring
//   division and loads the output register; only then does it pop the next job.
//   The front holds src while a job waits in the queue, and while the back works
//   on the last pixel of a frame.
// Reset: counters and control clear, registers take their reset
//   values; the line ring is not cleared (only written entries are read).
// Stall: a result waits in the output register while res.ready is low; the
//   back part then stops and the front stops once the queue holds a job.
module gaussian_blur_border_renorm_unit #(
  parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF,
  parameter int RADIUS    = gbr_pkg::RADIUS_DEF,
  parameter int COEF_BITS = gbr_pkg::COEF_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data,
  gbr_in_if.sink                         src,
  gbr_out_if.source                      res
);
  import gbr_pkg::*;

  localparam int RING   = 2 * RADIUS + 2;
  localparam int DEPTH  = RING * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EW_W   = $clog2(MAX_WIDTH + 1);

  logic [FW_W-1:0]      frame_width;
  logic [FH_W-1:0]      frame_height;
  logic [COEF_BITS-1:0] coef [4];
  logic                 restart;

  logic [EW_W-1:0]  eff_w;
  logic [ROW_W-1:0] eff_h;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic push, pop, q_valid, q_empty, busy_last;
  job_t push_job, q_head;

  // geometry writes clear the frame counters at the same edge
  assign restart = cfg_we &&
                   ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      coef[0]      <= COEF_BITS'(COEF_CENTER_RST);
      coef[1]      <= COEF_BITS'(COEF_ONE_RST);
      coef[2]      <= COEF_BITS'(COEF_TWO_RST);
      coef[3]      <= COEF_BITS'(COEF_THREE_RST);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= FW_W'(cfg_data);
          REG_FRAME_HEIGHT: frame_height <= FH_W'(cfg_data);
          REG_COEF_CENTER:  coef[0] <= COEF_BITS'(cfg_data);
          REG_COEF_ONE:     coef[1] <= COEF_BITS'(cfg_data);
          REG_COEF_TWO:     coef[2] <= COEF_BITS'(cfg_data);
          REG_COEF_THREE:   coef[3] <= COEF_BITS'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // Zero width or height count as one, width above the line size is clipped
  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(frame_width);
    end
    eff_h = (frame_height == '0) ? ROW_W'(1) : ROW_W'(frame_height);
  end

  gbr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gbr_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .RADIUS   (RADIUS),
    .EW_W     (EW_W),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .hold     (~q_empty | busy_last),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .src      (src),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .push     (push),
    .push_job (push_job)
  );

  gbr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .valid   (q_valid),
    .empty   (q_empty),
    .head    (q_head)
  );

  gbr_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .RADIUS   (RADIUS),
    .COEF_BITS(COEF_BITS),
    .EW_W     (EW_W),
    .ADDR_W   (ADDR_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .coef     (coef),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .busy_last(busy_last),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res      (res)
  );

endmodule

FILE: test/gaussian_blur_border_renorm_unit_test.sv
// Testbench for gaussian_blur_border_renorm_unit: random frames in raster order with
// drain ticks, checked pixel by pixel against a predictor of the edge-renormalized blur.
// Depends on gbr_pkg, gbr_in_if, gbr_out_if and the block's RTL.
`timescale 1ns / 100ps

module gaussian_blur_border_renorm_unit_test;
  import gbr_pkg::*;

  localparam int LINE_PIXELS = MAX_WIDTH_DEF;
  localparam int RING_LINES  = 2 * RADIUS_DEF + 2;
  localparam int IDLE_CYCLES = 120;   // longer than the back part needs for one output

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } blurred_pixel_t;

  // Predicts the smoothed stream and holds the pixels still owed by the block.
  class blur_scoreboard;
    logic [7:0]        ring[RING_LINES * LINE_PIXELS];
    int unsigned       in_col, in_row, out_col, out_row;
    int unsigned       width_reg, height_reg;
    longint unsigned   coef[4];
    blurred_pixel_t    owed[$];
    int                errors;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      coef[0] = COEF_CENTER_RST;
      coef[1] = COEF_ONE_RST;
      coef[2] = COEF_TWO_RST;
      coef[3] = COEF_THREE_RST;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      errors = 0;
    endfunction

    function int unsigned line_len();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_PIXELS) return LINE_PIXELS;
      return width_reg;
    endfunction

    function int unsigned line_count();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // True while a whole frame is in and its outputs are still pending.
    function bit frame_in();
      return in_row == line_count();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = val[FW_W-1:0];
        REG_FRAME_HEIGHT: height_reg = val[FH_W-1:0];
        REG_COEF_CENTER:  coef[0] = val;
        REG_COEF_ONE:     coef[1] = val;
        REG_COEF_TWO:     coef[2] = val;
        REG_COEF_THREE:   coef[3] = val;
        default: ;
      endcase
      if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
    endfunction

    function logic [7:0] blur_at(int r0, int c0, int w, int h);
      longint unsigned num, den, wt;
      int r, c;
      num = 0; den = 0;
      for (int dy = -RADIUS_DEF; dy <= RADIUS_DEF; dy++) begin
        r = r0 + dy;
        if (r < 0 || r >= h) continue;
        for (int dx = -RADIUS_DEF; dx <= RADIUS_DEF; dx++) begin
          c = c0 + dx;
          if (c < 0 || c >= w) continue;
          wt = coef[dx < 0 ? -dx : dx] * coef[dy < 0 ? -dy : dy];
          num += wt * ring[(r % RING_LINES) * LINE_PIXELS + c];
          den += wt;
        end
      end
      if (den == 0) return 8'd0;
      num = num / den;
      return (num > 255) ? 8'd255 : num[7:0];
    endfunction

    function void note_input(logic act, logic [7:0] pix);
      int unsigned w, h, nr, nc;
      blurred_pixel_t px;
      w = line_len();
      h = line_count();
      if (in_col >= w || in_row > h || out_col >= w || out_row >= h) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      // a pixel past a complete frame is dropped and acts as a drain
      if (act == ACT_PIXEL && in_row < h) begin
        ring[(in_row % RING_LINES) * LINE_PIXELS + in_col] = pix;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      nr = out_row + RADIUS_DEF;
      if (nr > h - 1) nr = h - 1;
      nc = out_col + RADIUS_DEF;
      if (nc > w - 1) nc = w - 1;
      if (!(in_row > nr || (in_row == nr && in_col > nc))) return;
      px.pixel = blur_at(out_row, out_col, w, h);
      px.last  = (out_row == h - 1 && out_col == w - 1);
      owed.push_back(px);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) begin
          out_row = 0; in_row = 0; in_col = 0;
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] pix, logic last);
      blurred_pixel_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected pixel %0d", pix));
        return;
      end
      want = owed.pop_front();
      if (pix !== want.pixel)
        report($sformatf("pixel_out %0d, predicted %0d", pix, want.pixel));
      if (last !== want.last)
        report($sformatf("frame_end %0b, predicted %0b", last, want.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gbr_in_if  src_if();
  gbr_out_if res_if();

  gaussian_blur_border_renorm_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (src_if),
    .res       (res_if)
  );

  blur_scoreboard sb = new();

  int burst_left;      // items left in the current sender burst
  bit steady_send;     // no gaps at all while set
  int results_seen;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Output monitor: ready is driven by NBA, so values read here are pre-edge.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      sb.check_result(res_if.pixel_out, res_if.frame_end);
      results_seen++;
    end
  end

  // Receiver: runs one of four random stall patterns at a time; one long hold-off after
  // 60 results so the queue fills and src backs up.
  initial begin
    int mode;
    int hold;
    bit held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 64; k++) begin
        if (!held && results_seen >= 60) begin
          held = 1'b1;
          res_if.ready <= 1'b0;
          for (hold = 0; hold < 1500; hold++) @(posedge clk);
        end
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= k[0];
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until accepted; a gap may come first.
  task send_item(logic act, logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        src_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    src_if.valid    <= 1'b1;
    src_if.action   <= act;
    src_if.pixel_in <= pix;
    do @(posedge clk); while (!src_if.ready);
    sb.note_input(act, pix);
  endtask

  task wait_idle();
    src_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with nothing in flight.
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task set_coefs(int c0, int c1, int c2, int c3);
    write_reg(REG_COEF_CENTER, CFG_DATA_W'(c0));
    write_reg(REG_COEF_ONE, CFG_DATA_W'(c1));
    write_reg(REG_COEF_TWO, CFG_DATA_W'(c2));
    write_reg(REG_COEF_THREE, CFG_DATA_W'(c3));
  endtask

  function logic [7:0] some_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame: pixels with stray drains mixed in, then drains (and dropped
  // pixels) until the last row is out. cut > 0 abandons the frame early.
  task run_frame(int cut, inout int sent);
    int total;
    total = sb.line_len() * sb.line_count();
    for (int i = 0; i < total; i++) begin
      if (cut > 0 && i == cut) return;
      if ($urandom_range(0, 9) == 0) begin
        send_item(ACT_DRAIN, 8'($urandom_range(0, 255)));
        sent++;
      end
      send_item(ACT_PIXEL, some_pixel());
      sent++;
    end
    while (sb.frame_in()) begin
      if ($urandom_range(0, 3) == 0) send_item(ACT_PIXEL, some_pixel());
      else send_item(ACT_DRAIN, 8'($urandom_range(0, 255)));
      sent++;
    end
  endtask

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int sent;
    int frame_no;
    int w, h;
    sent = 0;
    burst_left = 0;
    steady_send = 1'b0;
    results_seen = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= '0;
    src_if.valid <= 1'b0;
    src_if.action <= ACT_PIXEL;
    src_if.pixel_in <= 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset coefficients on a 3x2 frame with extreme pixels, a drain
    // with nothing ready, and pixels dropped after the frame is complete.
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 2);
    send_item(ACT_DRAIN, 8'hff);
    send_item(ACT_PIXEL, 8'd0);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_PIXEL, 8'd255);
    send_item(ACT_PIXEL, 8'd0);
    send_item(ACT_PIXEL, 8'd128);
    send_item(ACT_PIXEL, 8'd255);
    while (sb.frame_in()) send_item(ACT_PIXEL, 8'd77);
    // Zero weight sum, and width/height of zero counting as one.
    set_coefs(0, 0, 0, 0);
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    send_item(ACT_PIXEL, 8'd200);
    send_item(ACT_DRAIN, 8'd0);
    set_coefs(65535, 65535, 65535, 65535);
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 3);
    run_frame(0, sent);

    // Random frames, mostly small, with a few geometry extremes.
    sent = 0;
    frame_no = 0;
    while (sent < 1300) begin
      steady_send = ($urandom_range(0, 4) == 0);
      case (frame_no)
        3: begin
          write_reg(REG_FRAME_WIDTH, 2047);      // clamps to the line length
          write_reg(REG_FRAME_HEIGHT, 1);
          run_frame(0, sent);
        end
        6: begin
          write_reg(REG_FRAME_WIDTH, LINE_PIXELS);
          write_reg(REG_FRAME_HEIGHT, 1);
          run_frame(96, sent);
        end
        9: begin
          write_reg(REG_FRAME_WIDTH, 1);
          write_reg(REG_FRAME_HEIGHT, 8191);
          run_frame(20, sent);
        end
        12: begin
          write_reg(REG_FRAME_WIDTH, 2);
          write_reg(REG_FRAME_HEIGHT, 4096);
          run_frame(30, sent);
        end
        default: begin
          if ($urandom_range(0, 2) == 0)
            set_coefs($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
          else if ($urandom_range(0, 5) == 0)
            set_coefs(0, $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
          // a large geometry left over from an extreme frame is always replaced
          if ($urandom_range(0, 3) != 0 || sb.line_len() * sb.line_count() > 480) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            h = $urandom_range(0, 10);
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
          end
          // about one frame in eight is broken off part way
          if ($urandom_range(0, 7) == 0)
            run_frame($urandom_range(1, sb.line_len() * sb.line_count()), sent);
          else
            run_frame(0, sent);
        end
      endcase
      frame_no++;
    end

    src_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gbr_pkg.sv
rtl/gbr_in_if.sv
rtl/gbr_out_if.sv
rtl/gbr_ram.sv
rtl/gbr_queue.sv
rtl/gbr_front.sv
rtl/gbr_back.sv
rtl/gaussian_blur_border_renorm_unit.sv
test/gaussian_blur_border_renorm_unit_test.sv
